// ===== rtl/pfgh_pkg.sv =====
// ----------------------------------------------------------------------------
// Photon flux grid histogram package
// Shared constants, types and helper functions of the histogram core.
// ----------------------------------------------------------------------------
`default_nettype none

package pfgh_pkg;

   localparam int COL_BITS     = 6;
   localparam int ROW_BITS     = 6;
   localparam int ADDR_BITS    = COL_BITS + ROW_BITS;
   localparam int CELLS        = 1 << ADDR_BITS;
   localparam int COUNT_BITS   = 32;
   localparam int CORDIC_STEPS = 24;

   localparam logic [6:0]  MAX_COLUMNS = 7'd64;
   localparam logic [6:0]  MAX_ROWS    = 7'd64;
   localparam logic [6:0]  MIN_DIV     = 7'd2;
   localparam logic [31:0] TWO_PI_Q29  = 32'd3373259426;
   localparam logic [31:0] QUARTER     = 32'h4000_0000;
   localparam logic [31:0] THREE_QTR   = 32'hC000_0000;

   typedef enum logic [2:0] {
      REG_SURFACE_MODE = 3'd0,
      REG_ACTIVE_SIDE  = 3'd1,
      REG_X_ORIGIN     = 3'd2,
      REG_Y_ORIGIN     = 3'd3,
      REG_X_INV_SPAN   = 3'd4,
      REG_Y_INV_SPAN   = 3'd5,
      REG_GRID_COLUMNS = 3'd6,
      REG_GRID_ROWS    = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      E_CLEAR,
      E_SKIP,
      E_DROP,
      E_HIT
   } entry_kind_type;

   typedef enum logic [2:0] {
      F_IDLE,
      F_PREP,
      F_CORD,
      F_ANGLE,
      F_SUB,
      F_MUL,
      F_BIN,
      F_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      B_CLEAR,
      B_IDLE,
      B_UPDATE
   } back_state_type;

   typedef struct packed {
      logic        surface_mode;
      logic        active_side;
      logic [31:0] x_origin;
      logic [31:0] y_origin;
      logic [31:0] x_inv_span;
      logic [31:0] y_inv_span;
      logic [6:0]  grid_columns;
      logic [6:0]  grid_rows;
   } cfg_type;

   typedef struct packed {
      entry_kind_type        kind;
      logic [COL_BITS-1:0]   fine_col;
      logic [ROW_BITS-1:0]   fine_row;
      logic [COL_BITS-1:0]   coarse_col;
      logic [ROW_BITS-1:0]   coarse_row;
   } entry_type;

   function automatic logic [31:0] atan_bam(input logic [4:0] i);
      logic [31:0] r;
      case (i)
         5'd0:  r = 32'd536870912;
         5'd1:  r = 32'd316933406;
         5'd2:  r = 32'd167458907;
         5'd3:  r = 32'd85004756;
         5'd4:  r = 32'd42667331;
         5'd5:  r = 32'd21354465;
         5'd6:  r = 32'd10679838;
         5'd7:  r = 32'd5340245;
         5'd8:  r = 32'd2670163;
         5'd9:  r = 32'd1335087;
         5'd10: r = 32'd667544;
         5'd11: r = 32'd333772;
         5'd12: r = 32'd166886;
         5'd13: r = 32'd83443;
         5'd14: r = 32'd41722;
         5'd15: r = 32'd20861;
         5'd16: r = 32'd10430;
         5'd17: r = 32'd5215;
         5'd18: r = 32'd2608;
         5'd19: r = 32'd1304;
         5'd20: r = 32'd652;
         5'd21: r = 32'd326;
         5'd22: r = 32'd163;
         5'd23: r = 32'd81;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

   function automatic logic [6:0] clamp_div(input logic [6:0] v, input logic [6:0] hi);
      logic [6:0] r;
      if (v < MIN_DIV) begin
         r = MIN_DIV;
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      logic [COUNT_BITS-1:0] r;
      if (&v) begin
         r = v;
      end else begin
         r = v + COUNT_BITS'(1);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/pfgh_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pfgh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/pfgh_front.sv =====
// ----------------------------------------------------------------------------
// Histogram front end
// Accepts requests, computes the cylinder angle and the fine and coarse bins.
// ----------------------------------------------------------------------------
`default_nettype none

module pfgh_front
   import pfgh_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_mode,
   input  wire logic [31:0] req_pos_x,
   input  wire logic [31:0] req_pos_y,
   input  wire logic [31:0] req_pos_z,
   input  wire logic        req_hit_side,
   input  wire cfg_type     cfg,
   output logic             push_valid,
   input  wire logic        push_ready,
   output entry_type        push_entry
);

   front_state_type state_ff, state_in;
   entry_type       entry_ff, entry_in;
   logic [31:0]     pos_x_ff, pos_x_in;
   logic [31:0]     pos_y_ff, pos_y_in;
   logic [31:0]     pos_z_ff, pos_z_in;
   logic [32:0]     cx_ff, cx_in;
   logic [34:0]     cord_x_ff, cord_x_in;
   logic [34:0]     cord_y_ff, cord_y_in;
   logic [31:0]     cord_z_ff, cord_z_in;
   logic [4:0]      iter_ff, iter_in;
   logic            zero_ff, zero_in;
   logic [33:0]     dx_ff, dx_in;
   logic [33:0]     dz_ff, dz_in;
   logic [63:0]     prx_ff, prx_in;
   logic [63:0]     prz_ff, prz_in;
   logic            oorx_ff, oorx_in;
   logic            oorz_ff, oorz_in;

   logic [34:0] x0, y0, xs, ys;
   logic [63:0] ang_prod;
   logic [6:0]  w, h;
   logic [31:0] px, pz;
   logic [38:0] fc_prod, cc_prod, fr_prod, cr_prod;
   logic        oor;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      entry_ff  <= entry_in;
      pos_x_ff  <= pos_x_in;
      pos_y_ff  <= pos_y_in;
      pos_z_ff  <= pos_z_in;
      cx_ff     <= cx_in;
      cord_x_ff <= cord_x_in;
      cord_y_ff <= cord_y_in;
      cord_z_ff <= cord_z_in;
      iter_ff   <= iter_in;
      zero_ff   <= zero_in;
      dx_ff     <= dx_in;
      dz_ff     <= dz_in;
      prx_ff    <= prx_in;
      prz_ff    <= prz_in;
      oorx_ff   <= oorx_in;
      oorz_ff   <= oorz_in;
   end

   always_comb begin
      state_in  = state_ff;
      entry_in  = entry_ff;
      pos_x_in  = pos_x_ff;
      pos_y_in  = pos_y_ff;
      pos_z_in  = pos_z_ff;
      cx_in     = cx_ff;
      cord_x_in = cord_x_ff;
      cord_y_in = cord_y_ff;
      cord_z_in = cord_z_ff;
      iter_in   = iter_ff;
      zero_in   = zero_ff;
      dx_in     = dx_ff;
      dz_in     = dz_ff;
      prx_in    = prx_ff;
      prz_in    = prz_ff;
      oorx_in   = oorx_ff;
      oorz_in   = oorz_ff;
      push_valid = 1'b0;

      x0 = {{3{pos_x_ff[31]}}, pos_x_ff};
      y0 = {{3{pos_y_ff[31]}}, pos_y_ff};
      xs = $signed(cord_x_ff) >>> iter_ff;
      ys = $signed(cord_y_ff) >>> iter_ff;
      ang_prod = 64'(cord_z_ff) * 64'(TWO_PI_Q29);
      w = clamp_div(cfg.grid_columns, MAX_COLUMNS);
      h = clamp_div(cfg.grid_rows, MAX_ROWS);
      px = (cfg.x_inv_span == 32'd0) ? 32'd0 : prx_ff[31:0];
      pz = (cfg.y_inv_span == 32'd0) ? 32'd0 : prz_ff[31:0];
      fc_prod = 39'(px) * 39'(w);
      cc_prod = 39'(px) * 39'(w - 7'd1);
      fr_prod = 39'(pz) * 39'(h);
      cr_prod = 39'(pz) * 39'(h - 7'd1);
      oor = oorx_ff || oorz_ff || (prx_ff[63:32] != 32'd0) || (prz_ff[63:32] != 32'd0);

      unique case (state_ff)
         F_IDLE: begin
            if (start) begin
               pos_x_in = req_pos_x;
               pos_y_in = req_pos_y;
               pos_z_in = req_pos_z;
               entry_in = '0;
               if (req_mode) begin
                  entry_in.kind = E_CLEAR;
                  state_in = F_PUSH;
               end else if (req_hit_side != cfg.active_side) begin
                  entry_in.kind = E_SKIP;
                  state_in = F_PUSH;
               end else begin
                  entry_in.kind = E_HIT;
                  state_in = F_PREP;
               end
            end
         end
         F_PREP: begin
            iter_in = 5'd0;
            zero_in = (pos_x_ff == 32'd0) && (pos_y_ff == 32'd0);
            if (!cfg.surface_mode) begin
               cx_in = {pos_x_ff[31], pos_x_ff};
               state_in = F_SUB;
            end else begin
               state_in = F_CORD;
               if (!pos_x_ff[31]) begin
                  cord_x_in = x0;
                  cord_y_in = y0;
                  cord_z_in = 32'd0;
               end else if (!pos_y_ff[31]) begin
                  cord_x_in = y0;
                  cord_y_in = 35'd0 - x0;
                  cord_z_in = QUARTER;
               end else begin
                  cord_x_in = 35'd0 - y0;
                  cord_y_in = x0;
                  cord_z_in = THREE_QTR;
               end
            end
         end
         F_CORD: begin
            if (!cord_y_ff[34]) begin
               cord_x_in = cord_x_ff + ys;
               cord_y_in = cord_y_ff - xs;
               cord_z_in = cord_z_ff + atan_bam(iter_ff);
            end else begin
               cord_x_in = cord_x_ff - ys;
               cord_y_in = cord_y_ff + xs;
               cord_z_in = cord_z_ff - atan_bam(iter_ff);
            end
            iter_in = iter_ff + 5'd1;
            if (iter_ff == 5'(CORDIC_STEPS - 1)) begin
               state_in = F_ANGLE;
            end
         end
         F_ANGLE: begin
            cx_in = zero_ff ? 33'd0 : {14'd0, ang_prod[63:45]};
            state_in = F_SUB;
         end
         F_SUB: begin
            dx_in = {cx_ff[32], cx_ff} - {{2{cfg.x_origin[31]}}, cfg.x_origin};
            dz_in = {{2{pos_z_ff[31]}}, pos_z_ff} - {{2{cfg.y_origin[31]}}, cfg.y_origin};
            state_in = F_MUL;
         end
         F_MUL: begin
            prx_in  = 64'(dx_ff[31:0]) * 64'(cfg.x_inv_span);
            prz_in  = 64'(dz_ff[31:0]) * 64'(cfg.y_inv_span);
            oorx_in = (cfg.x_inv_span != 32'd0) && (dx_ff[33] || dx_ff[32]);
            oorz_in = (cfg.y_inv_span != 32'd0) && (dz_ff[33] || dz_ff[32]);
            state_in = F_BIN;
         end
         F_BIN: begin
            if (oor) begin
               entry_in = '0;
               entry_in.kind = E_DROP;
            end else begin
               entry_in.kind       = E_HIT;
               entry_in.fine_col   = fc_prod[32 +: COL_BITS];
               entry_in.coarse_col = cc_prod[32 +: COL_BITS];
               entry_in.fine_row   = fr_prod[32 +: ROW_BITS];
               entry_in.coarse_row = cr_prod[32 +: ROW_BITS];
            end
            state_in = F_PUSH;
         end
         F_PUSH: begin
            push_valid = 1'b1;
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != F_IDLE);
   assign push_entry = entry_ff;

endmodule

`default_nettype wire

// ===== rtl/pfgh_queue.sv =====
// ----------------------------------------------------------------------------
// Histogram work queue
// Two-entry queue between the front end and the counting back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pfgh_queue
   import pfgh_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push_valid,
   output logic           push_ready,
   input  wire entry_type push_entry,
   output logic           pop_valid,
   input  wire logic      pop_ready,
   output entry_type      pop_entry
);

   entry_type  slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/pfgh_back.sv =====
// ----------------------------------------------------------------------------
// Histogram back end
// Clears and updates both grids, tracks peaks and total, drives results.
// ----------------------------------------------------------------------------
`default_nettype none

module pfgh_back
   import pfgh_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  pop_valid,
   output logic                       pop_ready,
   input  wire entry_type             pop_entry,
   output logic                       rsp_valid,
   output logic                       rsp_accepted,
   output logic                       rsp_out_of_range,
   output logic [COL_BITS-1:0]        rsp_cell_col,
   output logic [ROW_BITS-1:0]        rsp_cell_row,
   output logic [COUNT_BITS-1:0]      rsp_cell_count,
   output logic [COUNT_BITS-1:0]      rsp_peak_count,
   output logic [COL_BITS-1:0]        rsp_peak_col,
   output logic [ROW_BITS-1:0]        rsp_peak_row,
   output logic [COUNT_BITS-1:0]      rsp_coarse_peak_count,
   output logic [COUNT_BITS-1:0]      rsp_total_count
);

   back_state_type        state_ff, state_in;
   logic [ADDR_BITS-1:0]  clr_addr_ff, clr_addr_in;
   entry_type             cur_ff, cur_in;
   logic [COUNT_BITS-1:0] peak_ff, peak_in;
   logic [COL_BITS-1:0]   peak_col_ff, peak_col_in;
   logic [ROW_BITS-1:0]   peak_row_ff, peak_row_in;
   logic [COUNT_BITS-1:0] cpeak_ff, cpeak_in;
   logic [COUNT_BITS-1:0] total_ff, total_in;
   logic                  valid_ff, valid_in;
   logic                  acc_ff, acc_in;
   logic                  oor_ff, oor_in;
   logic [COL_BITS-1:0]   col_ff, col_in;
   logic [ROW_BITS-1:0]   row_ff, row_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;

   logic                  wr_en;
   logic [ADDR_BITS-1:0]  fine_waddr, coarse_waddr;
   logic [COUNT_BITS-1:0] fine_wdata, coarse_wdata;
   logic [COUNT_BITS-1:0] fine_rdata, coarse_rdata;
   logic [COUNT_BITS-1:0] fine_new, coarse_new;

   pfgh_ram #(.WIDTH(COUNT_BITS), .DEPTH(CELLS)) u_fine_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fine_waddr),
      .wr_data (fine_wdata),
      .rd_addr ({pop_entry.fine_row, pop_entry.fine_col}),
      .rd_data (fine_rdata)
   );

   pfgh_ram #(.WIDTH(COUNT_BITS), .DEPTH(CELLS)) u_coarse_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (coarse_waddr),
      .wr_data (coarse_wdata),
      .rd_addr ({pop_entry.coarse_row, pop_entry.coarse_col}),
      .rd_data (coarse_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= B_CLEAR;
         clr_addr_ff <= '0;
         peak_ff     <= '0;
         peak_col_ff <= '0;
         peak_row_ff <= '0;
         cpeak_ff    <= '0;
         total_ff    <= '0;
         valid_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         peak_ff     <= peak_in;
         peak_col_ff <= peak_col_in;
         peak_row_ff <= peak_row_in;
         cpeak_ff    <= cpeak_in;
         total_ff    <= total_in;
         valid_ff    <= valid_in;
      end
      cur_ff <= cur_in;
      acc_ff <= acc_in;
      oor_ff <= oor_in;
      col_ff <= col_in;
      row_ff <= row_in;
      cnt_ff <= cnt_in;
   end

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      cur_in      = cur_ff;
      peak_in     = peak_ff;
      peak_col_in = peak_col_ff;
      peak_row_in = peak_row_ff;
      cpeak_in    = cpeak_ff;
      total_in    = total_ff;
      valid_in    = 1'b0;
      acc_in      = 1'b0;
      oor_in      = 1'b0;
      col_in      = '0;
      row_in      = '0;
      cnt_in      = '0;
      pop_ready   = 1'b0;
      fine_new    = sat_inc(fine_rdata);
      coarse_new  = sat_inc(coarse_rdata);
      wr_en        = 1'b0;
      fine_waddr   = {cur_ff.fine_row, cur_ff.fine_col};
      coarse_waddr = {cur_ff.coarse_row, cur_ff.coarse_col};
      fine_wdata   = fine_new;
      coarse_wdata = coarse_new;

      unique case (state_ff)
         B_CLEAR: begin
            wr_en        = 1'b1;
            fine_waddr   = clr_addr_ff;
            coarse_waddr = clr_addr_ff;
            fine_wdata   = '0;
            coarse_wdata = '0;
            clr_addr_in  = clr_addr_ff + ADDR_BITS'(1);
            if (&clr_addr_ff) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (pop_valid) begin
               pop_ready = 1'b1;
               cur_in    = pop_entry;
               case (pop_entry.kind)
                  E_CLEAR: begin
                     peak_in     = '0;
                     peak_col_in = '0;
                     peak_row_in = '0;
                     cpeak_in    = '0;
                     total_in    = '0;
                     clr_addr_in = '0;
                     valid_in    = 1'b1;
                     state_in    = B_CLEAR;
                  end
                  E_SKIP: begin
                     valid_in = 1'b1;
                  end
                  E_DROP: begin
                     valid_in = 1'b1;
                     oor_in   = 1'b1;
                  end
                  default: begin
                     state_in = B_UPDATE;
                  end
               endcase
            end
         end
         B_UPDATE: begin
            wr_en = 1'b1;
            if (fine_new > peak_ff) begin
               peak_in     = fine_new;
               peak_col_in = cur_ff.fine_col;
               peak_row_in = cur_ff.fine_row;
            end
            if (coarse_new > cpeak_ff) begin
               cpeak_in = coarse_new;
            end
            total_in = sat_inc(total_ff);
            valid_in = 1'b1;
            acc_in   = 1'b1;
            col_in   = cur_ff.fine_col;
            row_in   = cur_ff.fine_row;
            cnt_in   = fine_new;
            state_in = B_IDLE;
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   assign rsp_valid             = valid_ff;
   assign rsp_accepted          = acc_ff;
   assign rsp_out_of_range      = oor_ff;
   assign rsp_cell_col          = col_ff;
   assign rsp_cell_row          = row_ff;
   assign rsp_cell_count        = cnt_ff;
   assign rsp_peak_count        = peak_ff;
   assign rsp_peak_col          = peak_col_ff;
   assign rsp_peak_row          = peak_row_ff;
   assign rsp_coarse_peak_count = cpeak_ff;
   assign rsp_total_count       = total_ff;

endmodule

`default_nettype wire

// ===== rtl/photon_flux_grid_histogram_core.sv =====
// ----------------------------------------------------------------------------
// Photon flux grid histogram core
// Bins photon hits into a fine and a coarse grid and tracks peaks and total.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; each request gives
// exactly one result, shown for one cycle with rsp_valid, and the receiver
// cannot stall it. Busy stays high while the front end works on a request: in
// prepare, subtract, multiply, bin and push for a planar hit, plus CORDIC
// (one of 24 iterations per cycle) and angle for a cylinder hit, only in
// push for a clear or inactive photon, and longer while the queue is full.
// The back end counts a photon by a read-modify-write of both grids. After
// reset and every clear request it zeroes all 4096 cells of both grids, and
// requests are still taken into a two-entry queue. Registers are to be
// written only while no request is outstanding; not enforced by the core.
`default_nettype none

module photon_flux_grid_histogram_core
   import pfgh_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_mode,
   input  wire logic [31:0] req_pos_x,
   input  wire logic [31:0] req_pos_y,
   input  wire logic [31:0] req_pos_z,
   input  wire logic        req_hit_side,
   output logic             rsp_valid,
   output logic             rsp_accepted,
   output logic             rsp_out_of_range,
   output logic [5:0]       rsp_cell_col,
   output logic [5:0]       rsp_cell_row,
   output logic [31:0]      rsp_cell_count,
   output logic [31:0]      rsp_peak_count,
   output logic [5:0]       rsp_peak_col,
   output logic [5:0]       rsp_peak_row,
   output logic [31:0]      rsp_coarse_peak_count,
   output logic [31:0]      rsp_total_count,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   cfg_type   cfg_ff, cfg_in;
   logic      push_valid, push_ready, pop_valid, pop_ready;
   entry_type push_entry, pop_entry;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            REG_SURFACE_MODE: cfg_in.surface_mode = csr_data[0];
            REG_ACTIVE_SIDE:  cfg_in.active_side  = csr_data[0];
            REG_X_ORIGIN:     cfg_in.x_origin     = csr_data;
            REG_Y_ORIGIN:     cfg_in.y_origin     = csr_data;
            REG_X_INV_SPAN:   cfg_in.x_inv_span   = csr_data;
            REG_Y_INV_SPAN:   cfg_in.y_inv_span   = csr_data;
            REG_GRID_COLUMNS: cfg_in.grid_columns = csr_data[6:0];
            REG_GRID_ROWS:    cfg_in.grid_rows    = csr_data[6:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.surface_mode <= 1'b0;
         cfg_ff.active_side  <= 1'b1;
         cfg_ff.x_origin     <= 32'd0;
         cfg_ff.y_origin     <= 32'd0;
         cfg_ff.x_inv_span   <= 32'd65536;
         cfg_ff.y_inv_span   <= 32'd65536;
         cfg_ff.grid_columns <= MAX_COLUMNS;
         cfg_ff.grid_rows    <= MAX_ROWS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pfgh_front u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_mode     (req_mode),
      .req_pos_x    (req_pos_x),
      .req_pos_y    (req_pos_y),
      .req_pos_z    (req_pos_z),
      .req_hit_side (req_hit_side),
      .cfg          (cfg_ff),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_entry   (push_entry)
   );

   pfgh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   pfgh_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .pop_valid             (pop_valid),
      .pop_ready             (pop_ready),
      .pop_entry             (pop_entry),
      .rsp_valid             (rsp_valid),
      .rsp_accepted          (rsp_accepted),
      .rsp_out_of_range      (rsp_out_of_range),
      .rsp_cell_col          (rsp_cell_col),
      .rsp_cell_row          (rsp_cell_row),
      .rsp_cell_count        (rsp_cell_count),
      .rsp_peak_count        (rsp_peak_count),
      .rsp_peak_col          (rsp_peak_col),
      .rsp_peak_row          (rsp_peak_row),
      .rsp_coarse_peak_count (rsp_coarse_peak_count),
      .rsp_total_count       (rsp_total_count)
   );

endmodule

`default_nettype wire

// ===== rtl/pfgh_checker.sv =====
// ----------------------------------------------------------------------------
// Histogram core checker
// Port-level assertions on the histogram core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pfgh_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic        rsp_accepted,
   input wire logic        rsp_out_of_range,
   input wire logic [31:0] rsp_cell_count,
   input wire logic [31:0] rsp_peak_count,
   input wire logic [31:0] rsp_total_count
);

   // A taken request always keeps the front end busy for the next cycle.
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after a request");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> !rsp_out_of_range)
      else $error("photon both counted and dropped");

   a_cell_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_accepted |-> rsp_cell_count == 32'd0)
      else $error("cell count shown for an uncounted request");

   a_peak_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> rsp_peak_count >= rsp_cell_count &&
                                    rsp_total_count != 32'd0)
      else $error("peak or total below the counted cell");

endmodule

bind photon_flux_grid_histogram_core pfgh_checker u_checker (.*);

`default_nettype wire

// ===== bench/photon_flux_grid_histogram_core_tb.sv =====
// ----------------------------------------------------------------------------
// Photon flux grid histogram core testbench
// Drives photon hit and clear requests through several grid settings, checks
// every result against a behavioral predictor of binning, counting and peaks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module photon_flux_grid_histogram_core_tb;
   import pfgh_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct {
      bit        mode;
      bit [31:0] pos_x;
      bit [31:0] pos_y;
      bit [31:0] pos_z;
      bit        hit_side;
   } photon_req_type;

   typedef struct {
      bit        accepted;
      bit        out_of_range;
      bit [5:0]  cell_col;
      bit [5:0]  cell_row;
      bit [31:0] cell_count;
      bit [31:0] peak_count;
      bit [5:0]  peak_col;
      bit [5:0]  peak_row;
      bit [31:0] coarse_peak_count;
      bit [31:0] total_count;
   } flux_rsp_type;

   localparam bit [31:0] ANGLE_STEP [24] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_mode = 1'b0;
   logic [31:0] req_pos_x = '0;
   logic [31:0] req_pos_y = '0;
   logic [31:0] req_pos_z = '0;
   logic req_hit_side = 1'b0;
   logic rsp_valid, rsp_accepted, rsp_out_of_range;
   logic [5:0] rsp_cell_col, rsp_cell_row, rsp_peak_col, rsp_peak_row;
   logic [31:0] rsp_cell_count, rsp_peak_count, rsp_coarse_peak_count, rsp_total_count;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   photon_req_type pending_reqs[$];
   flux_rsp_type   expected_rsps[$];
   photon_req_type current_req;
   cfg_type        shadow_cfg;
   bit [31:0]      fine_counts [CELLS];
   bit [31:0]      coarse_counts [CELLS];
   bit [31:0]      peak_value, coarse_peak_value, photon_total;
   bit [5:0]       peak_column, peak_line;
   bit             hold_requests = 1'b1;
   int             burst_left = 0;
   int             gap_left = 0;
   int             watchdog = 0;
   int             error_count = 0;
   int             counted_hits = 0;
   int             dropped_hits = 0;
   int             skipped_hits = 0;
   int             clear_count = 0;
   int             phase_count = 0;

   photon_flux_grid_histogram_core i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_pos_x(req_pos_x), .req_pos_y(req_pos_y),
      .req_pos_z(req_pos_z), .req_hit_side(req_hit_side),
      .rsp_valid(rsp_valid), .rsp_accepted(rsp_accepted),
      .rsp_out_of_range(rsp_out_of_range), .rsp_cell_col(rsp_cell_col),
      .rsp_cell_row(rsp_cell_row), .rsp_cell_count(rsp_cell_count),
      .rsp_peak_count(rsp_peak_count), .rsp_peak_col(rsp_peak_col),
      .rsp_peak_row(rsp_peak_row), .rsp_coarse_peak_count(rsp_coarse_peak_count),
      .rsp_total_count(rsp_total_count), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint angle_q16(longint x, longint y);
      bit [31:0] z;
      longint t, xs, ys;
      z = '0;
      if (x == 0 && y == 0) begin
         return 0;
      end
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y;
            y = -t;
            z = QUARTER;
         end else begin
            x = -y;
            y = t;
            z = THREE_QTR;
         end
      end
      for (int i = 0; i < 24; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + ANGLE_STEP[i];
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - ANGLE_STEP[i];
         end
      end
      return longint'((64'(z) * 64'(TWO_PI_Q29)) >> 45);
   endfunction

   function automatic bit bin_coord(longint coord, bit [31:0] origin, bit [31:0] inv,
                                    int div, output int fine, output int coarse);
      longint d;
      bit [63:0] p;
      d = coord - longint'($signed(origin));
      p = '0;
      fine = 0;
      coarse = 0;
      if (inv != 0) begin
         if (d < 0) begin
            return 1'b0;
         end
         p = 64'(d) * 64'(inv);
         if (p[63:32] != 0) begin
            return 1'b0;
         end
      end
      fine = int'((p * 64'(div)) >> 32);
      coarse = int'((p * 64'(div - 1)) >> 32);
      return 1'b1;
   endfunction

   function automatic int clamp_grid(bit [6:0] v);
      if (v < 2) begin
         return 2;
      end
      if (v > 64) begin
         return 64;
      end
      return int'(v);
   endfunction

   function automatic flux_rsp_type predict_flux(photon_req_type r);
      flux_rsp_type e;
      int w, h, fc, cc, fr, cr, fi, ci;
      longint cx;
      bit ok;
      e = '{default: '0};
      if (r.mode) begin
         fine_counts = '{default: '0};
         coarse_counts = '{default: '0};
         peak_value = 0;
         peak_column = 0;
         peak_line = 0;
         coarse_peak_value = 0;
         photon_total = 0;
         clear_count++;
      end else if (r.hit_side == shadow_cfg.active_side) begin
         w = clamp_grid(shadow_cfg.grid_columns);
         h = clamp_grid(shadow_cfg.grid_rows);
         cx = shadow_cfg.surface_mode ?
              angle_q16(longint'($signed(r.pos_x)), longint'($signed(r.pos_y))) :
              longint'($signed(r.pos_x));
         ok = bin_coord(cx, shadow_cfg.x_origin, shadow_cfg.x_inv_span, w, fc, cc);
         if (ok) begin
            ok = bin_coord(longint'($signed(r.pos_z)), shadow_cfg.y_origin,
                           shadow_cfg.y_inv_span, h, fr, cr);
         end
         if (ok && fc < w && fr < h && cc < w - 1 && cr < h - 1) begin
            fi = fr * 64 + fc;
            ci = cr * 64 + cc;
            if (~&fine_counts[fi]) begin
               fine_counts[fi]++;
            end
            if (~&coarse_counts[ci]) begin
               coarse_counts[ci]++;
            end
            if (fine_counts[fi] > peak_value) begin
               peak_value = fine_counts[fi];
               peak_column = fc[5:0];
               peak_line = fr[5:0];
            end
            if (coarse_counts[ci] > coarse_peak_value) begin
               coarse_peak_value = coarse_counts[ci];
            end
            if (~&photon_total) begin
               photon_total++;
            end
            e.accepted = 1'b1;
            e.cell_col = fc[5:0];
            e.cell_row = fr[5:0];
            e.cell_count = fine_counts[fi];
            counted_hits++;
         end else begin
            e.out_of_range = 1'b1;
            dropped_hits++;
         end
      end else begin
         skipped_hits++;
      end
      e.peak_count = peak_value;
      e.peak_col = peak_column;
      e.peak_row = peak_line;
      e.coarse_peak_count = coarse_peak_value;
      e.total_count = photon_total;
      return e;
   endfunction

   // Sender: bursts of requests separated by random gaps.
   always @(posedge clock) begin
      photon_req_type nxt;
      bit drive;
      if (reset) begin
         start <= 1'b0;
      end else begin
         drive = start;
         if (start && !busy) begin
            expected_rsps.insert(expected_rsps.size(), predict_flux(current_req));
            drive = 1'b0;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end
         if (!drive) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (!hold_requests && pending_reqs.size() > 0) begin
               nxt = pending_reqs.pop_front();
               current_req = nxt;
               req_mode <= nxt.mode;
               req_pos_x <= nxt.pos_x;
               req_pos_y <= nxt.pos_y;
               req_pos_z <= nxt.pos_z;
               req_hit_side <= nxt.hit_side;
               drive = 1'b1;
            end
         end
         start <= drive;
      end
   end

   task automatic check_field(string name, bit [31:0] exp_v, bit [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      flux_rsp_type e;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: result with no request outstanding", $time);
            error_count++;
         end else begin
            e = expected_rsps.pop_front();
            check_field("accepted", e.accepted, rsp_accepted);
            check_field("out_of_range", e.out_of_range, rsp_out_of_range);
            check_field("cell_col", e.cell_col, rsp_cell_col);
            check_field("cell_row", e.cell_row, rsp_cell_row);
            check_field("cell_count", e.cell_count, rsp_cell_count);
            check_field("peak_count", e.peak_count, rsp_peak_count);
            check_field("peak_col", e.peak_col, rsp_peak_col);
            check_field("peak_row", e.peak_row, rsp_peak_row);
            check_field("coarse_peak_count", e.coarse_peak_count, rsp_coarse_peak_count);
            check_field("total_count", e.total_count, rsp_total_count);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         watchdog <= 0;
      end else if (watchdog >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         watchdog <= watchdog + 1;
      end
   end

   task automatic write_csr(csr_index_type idx, bit [31:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic drain;
      @(negedge clock);
      hold_requests = 1'b0;
      wait (pending_reqs.size() == 0 && !start && expected_rsps.size() == 0);
      @(negedge clock);
      hold_requests = 1'b1;
      repeat (40) @(negedge clock);
   endtask

   task automatic program_grid(cfg_type c);
      write_csr(REG_SURFACE_MODE, 32'(c.surface_mode));
      write_csr(REG_ACTIVE_SIDE, 32'(c.active_side));
      write_csr(REG_X_ORIGIN, c.x_origin);
      write_csr(REG_Y_ORIGIN, c.y_origin);
      write_csr(REG_X_INV_SPAN, c.x_inv_span);
      write_csr(REG_Y_INV_SPAN, c.y_inv_span);
      write_csr(REG_GRID_COLUMNS, 32'(c.grid_columns));
      write_csr(REG_GRID_ROWS, 32'(c.grid_rows));
      shadow_cfg = c;
      phase_count++;
      @(negedge clock);
   endtask

   task automatic queue_req(bit mode, bit [31:0] x, bit [31:0] y, bit [31:0] z, bit side);
      photon_req_type r;
      r.mode = mode;
      r.pos_x = x;
      r.pos_y = y;
      r.pos_z = z;
      r.hit_side = side;
      pending_reqs.insert(pending_reqs.size(), r);
   endtask

   function automatic bit [31:0] coord_near(bit [31:0] origin, bit [31:0] inv);
      bit [63:0] span, off;
      int pick;
      span = (inv == 0) ? 64'h1_0000_0000 : (64'h1_0000_0000 / inv) + 1;
      off = 64'($urandom) % (span + span / 8 + 1);
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
         return $urandom;
      end
      if (pick == 1) begin
         return origin - $urandom_range(1, 1000);
      end
      return origin + off[31:0];
   endfunction

   task automatic queue_random(int n);
      bit [31:0] x, y;
      int sh;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 29) == 0) begin
            queue_req(1'b0, $urandom, $urandom, $urandom, $urandom_range(0, 1));
            continue;
         end
         if (shadow_cfg.surface_mode) begin
            sh = $urandom_range(0, 31);
            x = $signed($urandom) >>> sh;
            y = $signed($urandom) >>> sh;
         end else begin
            x = coord_near(shadow_cfg.x_origin, shadow_cfg.x_inv_span);
            y = $urandom;
         end
         queue_req(1'b0, x, y, coord_near(shadow_cfg.y_origin, shadow_cfg.y_inv_span),
                   ($urandom_range(0, 9) == 0) ? ~shadow_cfg.active_side :
                   shadow_cfg.active_side);
      end
   endtask

   initial begin
      cfg_type c;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      c = '{surface_mode: 1'b0, active_side: 1'b1, x_origin: 32'd0, y_origin: 32'd0,
            x_inv_span: 32'd65536, y_inv_span: 32'd65536, grid_columns: 7'd64,
            grid_rows: 7'd64};
      program_grid(c);
      queue_req(1'b0, 32'd0, 32'd0, 32'd0, 1'b1);
      queue_req(1'b0, 32'd65535, 32'hFFFF_FFFF, 32'd65535, 1'b1);
      queue_req(1'b0, 32'd65536, 32'd0, 32'd100, 1'b1);
      queue_req(1'b0, 32'd100, 32'd0, 32'hFFFF_FFFF, 1'b1);
      queue_req(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b1);
      queue_req(1'b0, 32'd300, 32'd0, 32'd300, 1'b0);
      for (int i = 0; i < 4; i++) begin
         queue_req(1'b0, 32'd40000, 32'd0, 32'd20000, 1'b1);
      end
      queue_req(1'b0, 32'd65535, 32'd0, 32'd65535, 1'b1);
      queue_req(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      queue_req(1'b0, 32'd1000, 32'd0, 32'd1000, 1'b1);
      drain();

      c = '{surface_mode: 1'b1, active_side: 1'b0, x_origin: 32'd0, y_origin: 32'd0,
            x_inv_span: 32'd10430, y_inv_span: 32'd0, grid_columns: 7'd37,
            grid_rows: 7'd5};
      program_grid(c);
      queue_req(1'b0, 32'd0, 32'd0, 32'd5, 1'b0);
      queue_req(1'b0, 32'hFFFF_FFFF, 32'd0, 32'd5, 1'b0);
      queue_req(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd5, 1'b0);
      queue_req(1'b0, 32'd0, 32'hFFFF_FFFF, 32'd5, 1'b0);
      queue_req(1'b0, 32'd1, 32'd0, 32'h8000_0000, 1'b0);
      queue_req(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
      queue_req(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0, 1'b0);
      queue_random(150);
      drain();

      c = '{surface_mode: 1'b0, active_side: 1'b1, x_origin: 32'hFFF8_0000,
            y_origin: 32'hFFFC_0000, x_inv_span: 32'd4096, y_inv_span: 32'd8192,
            grid_columns: 7'd2, grid_rows: 7'd2};
      program_grid(c);
      queue_random(170);
      queue_req(1'b1, 32'd0, 32'd0, 32'd0, 1'b0);
      queue_random(20);
      drain();

      c = '{surface_mode: 1'b0, active_side: 1'b0, x_origin: 32'h8000_0000,
            y_origin: 32'h7FFF_FFFF, x_inv_span: 32'hFFFF_FFFF, y_inv_span: 32'd0,
            grid_columns: 7'd1, grid_rows: 7'd127};
      program_grid(c);
      queue_random(150);
      drain();

      c = '{surface_mode: 1'b1, active_side: 1'b1, x_origin: 32'hFFFF_0000,
            y_origin: 32'd0, x_inv_span: 32'd5000, y_inv_span: 32'd131072,
            grid_columns: 7'd0, grid_rows: 7'd65};
      program_grid(c);
      queue_random(170);
      queue_req(1'b1, 32'd0, 32'd0, 32'd0, 1'b1);
      queue_random(20);
      drain();

      c = '{surface_mode: 1'b0, active_side: 1'b1, x_origin: 32'h0001_0000,
            y_origin: 32'hFFFF_8000, x_inv_span: 32'd32768, y_inv_span: 32'd16384,
            grid_columns: 7'd7, grid_rows: 7'd3};
      program_grid(c);
      queue_random(170);
      drain();

      c = '{surface_mode: 1'b1, active_side: 1'b1, x_origin: 32'd0, y_origin: 32'd0,
            x_inv_span: 32'd10430, y_inv_span: 32'd65536, grid_columns: 7'd64,
            grid_rows: 7'd64};
      program_grid(c);
      queue_random(180);
      drain();

      $display("Covered %0d grid settings: %0d counted, %0d dropped, %0d ignored photons,",
               phase_count, counted_hits, dropped_hits, skipped_hits);
      $display("and %0d clear requests.", clear_count);
      if (error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
